@@ sv/sdspi_pkg.sv @@
// ----------------------------------------------------------------------------
// SD SPI host package
// Types, constants and CRC helpers shared by the SD card SPI host sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package sdspi_pkg;

   localparam int unsigned BLOCK_BYTES = 512;
   localparam int unsigned CNT_W = $clog2(BLOCK_BYTES + 1);

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_INIT  = 3'd1,
      OP_READ  = 3'd2,
      OP_WRITE = 3'd3,
      OP_XDONE = 3'd4,
      OP_WBYTE = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BAD_R1  = 3'd1,
      ST_TIMEOUT = 3'd2,
      ST_CRC     = 3'd3,
      ST_REJECT  = 3'd4,
      ST_BUSY    = 3'd5
   } status_type;

   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_SETTLE  = 1'b1;

   localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0] CMD_IF_COND   = 6'd8;
   localparam logic [5:0] CMD_READ_BLK  = 6'd17;
   localparam logic [5:0] CMD_WRITE_BLK = 6'd24;
   localparam logic [5:0] CMD_SD_SEND_OP = 6'd41;
   localparam logic [5:0] CMD_APP       = 6'd55;

   localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
   localparam logic [7:0]  CMD_START   = 8'h40;
   localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
   localparam logic [7:0]  DATA_TOKEN  = 8'hFE;
   localparam logic [7:0]  R1_IDLE     = 8'h01;
   localparam logic [4:0]  DRESP_OK    = 5'b00101;
   localparam logic [15:0] TIMER_MAX   = 16'hFFFF;

   function automatic logic [47:0] cmd_frame(input logic [5:0] cmd,
                                             input logic [31:0] arg);
      logic [39:0] body;
      logic [6:0]  crc;
      logic        fb;
      body = {CMD_START | {2'b00, cmd}, arg};
      crc  = '0;
      for (int i = 39; i >= 0; i--) begin
         fb  = body[i] ^ crc[6];
         crc = {crc[5:0], 1'b0};
         if (fb) begin
            crc = crc ^ 7'h09;
         end
      end
      return {body, crc, 1'b1};
   endfunction

   function automatic logic [15:0] crc16_add(input logic [15:0] crc_i,
                                             input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ sv/sdspi_req_if.sv @@
// ----------------------------------------------------------------------------
// SD SPI request channel
// Valid/ready channel carrying one host request.
// ----------------------------------------------------------------------------
`default_nettype none
interface sdspi_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [31:0] block_address;
   logic [7:0]  rx_byte;
   logic [7:0]  write_byte;
   modport source (output valid, opcode, block_address, rx_byte, write_byte,
                   input ready);
   modport sink   (input valid, opcode, block_address, rx_byte, write_byte,
                   output ready);
endinterface
`default_nettype wire

@@ sv/sdspi_rsp_if.sv @@
// ----------------------------------------------------------------------------
// SD SPI response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none
interface sdspi_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       chip_select_on;
   logic       read_valid;
   logic [7:0] read_data;
   logic       write_request;
   logic       done_res;
   logic [2:0] status;
   logic       fast_clock;
   modport source (output valid, tx_valid, tx_byte, chip_select_on, read_valid,
                   read_data, write_request, done_res, status, fast_clock,
                   input ready);
   modport sink   (input valid, tx_valid, tx_byte, chip_select_on, read_valid,
                   read_data, write_request, done_res, status, fast_clock,
                   output ready);
endinterface
`default_nettype wire

@@ sv/sd_card_spi_host_sequencer.sv @@
// ----------------------------------------------------------------------------
// SD card SPI host sequencer
// Byte-level init / single-block read / single-block write sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | opcode, block_address, rx_byte, write_byte
//  rsp     | out | valid/ready | tx/select/read/write/done/status/fast
//  csr     | in  | write only  | csr_index, csr_wdata
//
//  One request per cycle; its response is registered and shown the next cycle.
//  The response register is the only stall point: req.ready is low only while
//  a response is held and not taken. Synchronous reset returns the sequencer
//  to idle with select deasserted and the state and CSR registers at their defaults.
`default_nettype none
module sd_card_spi_host_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   sdspi_req_if.sink        req,
   sdspi_rsp_if.source      rsp,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   import sdspi_pkg::*;

   typedef enum logic [19:0] {
      PH_IDLE      = 20'h00001,
      PH_BURST     = 20'h00002,
      PH_DLY_BURST = 20'h00004,
      PH_DLY_CS    = 20'h00008,
      PH_DLY_CMD0  = 20'h00010,
      PH_CMD_PRE   = 20'h00020,
      PH_CMD_FRAME = 20'h00040,
      PH_CMD_POLL  = 20'h00080,
      PH_CMD_EXTRA = 20'h00100,
      PH_RD_TOKEN  = 20'h00200,
      PH_RD_DATA   = 20'h00400,
      PH_RD_CRC    = 20'h00800,
      PH_RD_IDLE   = 20'h01000,
      PH_WR_GAP    = 20'h02000,
      PH_WR_TOKEN  = 20'h04000,
      PH_WR_REQ    = 20'h08000,
      PH_WR_DATA   = 20'h10000,
      PH_WR_CRC    = 20'h20000,
      PH_WR_RESP   = 20'h40000,
      PH_WR_BUSY   = 20'h80000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [47:0] frame_ff, frame_in;
   logic [15:0] wait_ff, wait_in, loop_ff, loop_in;
   logic [15:0] crc_run_ff, crc_run_in, crc_rx_ff, crc_rx_in;
   logic        sel_ff, sel_in, fast_ff, fast_in;
   logic [7:0]  r1_ff, r1_in;
   logic [15:0] tmo_ff, settle_ff;

   logic        txv, rdv, done;
   logic [7:0]  tx, rd;
   status_type  st;

   logic        vld_ff;
   logic        o_txv_ff, o_rdv_ff, o_done_ff;
   logic [7:0]  o_tx_ff, o_rd_ff;
   logic [2:0]  o_st_ff;

   logic        take;
   assign req.ready = !vld_ff || rsp.ready;
   assign take      = req.valid && req.ready;

   logic [5:0]  cur_cmd;
   logic [7:0]  r1_use;
   logic [5:0]  nxt_cmd;
   logic [31:0] nxt_arg;
   logic        go_cmd;
   logic [47:0] nxt_frame;
   logic [2:0]  fidx;
   assign cur_cmd   = frame_ff[45:40];
   assign nxt_frame = cmd_frame(nxt_cmd, nxt_arg);

   always_comb begin
      phase_in = phase_ff; cnt_in = cnt_ff; frame_in = frame_ff;
      wait_in = wait_ff; loop_in = loop_ff; crc_run_in = crc_run_ff;
      crc_rx_in = crc_rx_ff; sel_in = sel_ff; fast_in = fast_ff; r1_in = r1_ff;
      txv = 1'b0; tx = '0; rdv = 1'b0; rd = '0; done = 1'b0; st = ST_OK;
      go_cmd = 1'b0; nxt_cmd = CMD_GO_IDLE; nxt_arg = '0;
      r1_use = r1_ff; fidx = '0;

      unique case (op_type'(req.opcode))
         OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (wait_ff != TIMER_MAX) wait_in = wait_ff + 16'd1;
               if (loop_ff != TIMER_MAX) loop_in = loop_ff + 16'd1;
            end
         end
         OP_INIT, OP_READ, OP_WRITE: begin
            if (phase_ff != PH_IDLE) begin
               done = 1'b1; st = ST_BUSY;
            end else if (req.opcode == OP_INIT) begin
               sel_in = 1'b0; fast_in = 1'b0; cnt_in = '0;
               phase_in = PH_BURST; txv = 1'b1; tx = IDLE_BYTE;
            end else begin
               go_cmd  = 1'b1;
               nxt_cmd = (req.opcode == OP_READ) ? CMD_READ_BLK : CMD_WRITE_BLK;
               nxt_arg = req.block_address;
            end
         end
         OP_XDONE: begin
            unique case (phase_ff)
               PH_BURST: begin
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_in < CNT_W'(10)) begin
                     txv = 1'b1; tx = IDLE_BYTE;
                  end else begin
                     phase_in = PH_DLY_BURST; wait_in = '0;
                  end
               end
               PH_CMD_PRE: begin
                  cnt_in = '0; phase_in = PH_CMD_FRAME;
                  txv = 1'b1; tx = frame_ff[47:40];
               end
               PH_CMD_FRAME: begin
                  cnt_in = cnt_ff + 1'b1;
                  fidx = cnt_in[2:0];
                  if (cnt_in < CNT_W'(6)) begin
                     txv = 1'b1;
                     case (fidx)
                        3'd1: tx = frame_ff[39:32];
                        3'd2: tx = frame_ff[31:24];
                        3'd3: tx = frame_ff[23:16];
                        3'd4: tx = frame_ff[15:8];
                        default: tx = frame_ff[7:0];
                     endcase
                  end else begin
                     phase_in = PH_CMD_POLL; wait_in = '0;
                     txv = 1'b1; tx = IDLE_BYTE;
                  end
               end
               PH_CMD_POLL, PH_CMD_EXTRA: begin
                  logic fin_cmd;
                  fin_cmd = 1'b0;
                  if (phase_ff == PH_CMD_POLL) begin
                     if (req.rx_byte[7]) begin
                        if (wait_ff > tmo_ff) begin
                           done = 1'b1; st = ST_TIMEOUT;
                        end else begin
                           txv = 1'b1; tx = IDLE_BYTE;
                        end
                     end else begin
                        r1_in = req.rx_byte; r1_use = req.rx_byte;
                        if (cur_cmd == CMD_IF_COND) begin
                           cnt_in = '0; phase_in = PH_CMD_EXTRA;
                           txv = 1'b1; tx = IDLE_BYTE;
                        end else begin
                           fin_cmd = 1'b1;
                        end
                     end
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                     if (cnt_in < CNT_W'(4)) begin
                        txv = 1'b1; tx = IDLE_BYTE;
                     end else begin
                        fin_cmd = 1'b1;
                     end
                  end
                  if (fin_cmd) begin
                     case (cur_cmd)
                        CMD_GO_IDLE: begin
                           if (r1_use != R1_IDLE) begin
                              done = 1'b1; st = ST_BAD_R1;
                           end else begin
                              phase_in = PH_DLY_CMD0; wait_in = '0;
                           end
                        end
                        CMD_IF_COND: begin
                           if (r1_use != R1_IDLE) begin
                              done = 1'b1; st = ST_BAD_R1;
                           end else begin
                              loop_in = '0;
                              go_cmd = 1'b1; nxt_cmd = CMD_APP;
                           end
                        end
                        CMD_APP: begin
                           if (r1_use != R1_IDLE) begin
                              done = 1'b1; st = ST_BAD_R1;
                           end else begin
                              go_cmd = 1'b1; nxt_cmd = CMD_SD_SEND_OP;
                              nxt_arg = ARG_HCS;
                           end
                        end
                        CMD_SD_SEND_OP: begin
                           if (r1_use == 8'h00) begin
                              fast_in = 1'b1; done = 1'b1; st = ST_OK;
                           end else if (loop_ff > tmo_ff) begin
                              done = 1'b1; st = ST_TIMEOUT;
                           end else begin
                              go_cmd = 1'b1; nxt_cmd = CMD_APP;
                           end
                        end
                        CMD_READ_BLK: begin
                           if (r1_use != 8'h00) begin
                              done = 1'b1; st = ST_BAD_R1;
                           end else begin
                              phase_in = PH_RD_TOKEN; wait_in = '0;
                              txv = 1'b1; tx = IDLE_BYTE;
                           end
                        end
                        default: begin
                           if (r1_use != 8'h00) begin
                              done = 1'b1; st = ST_BAD_R1;
                           end else begin
                              phase_in = PH_WR_GAP; txv = 1'b1; tx = IDLE_BYTE;
                           end
                        end
                     endcase
                  end
               end
               PH_RD_TOKEN: begin
                  if (req.rx_byte == DATA_TOKEN) begin
                     cnt_in = '0; crc_run_in = '0; phase_in = PH_RD_DATA;
                     txv = 1'b1; tx = IDLE_BYTE;
                  end else if (wait_ff > tmo_ff) begin
                     done = 1'b1; st = ST_TIMEOUT;
                  end else begin
                     txv = 1'b1; tx = IDLE_BYTE;
                  end
               end
               PH_RD_DATA: begin
                  rdv = 1'b1; rd = req.rx_byte;
                  crc_run_in = crc16_add(crc_run_ff, req.rx_byte);
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_in >= CNT_W'(BLOCK_BYTES)) begin
                     cnt_in = '0; phase_in = PH_RD_CRC;
                  end
                  txv = 1'b1; tx = IDLE_BYTE;
               end
               PH_RD_CRC: begin
                  crc_rx_in = {crc_rx_ff[7:0], req.rx_byte};
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_in < CNT_W'(2)) begin
                     txv = 1'b1; tx = IDLE_BYTE;
                  end else if (crc_rx_in != crc_run_ff) begin
                     done = 1'b1; st = ST_CRC;
                  end else begin
                     phase_in = PH_RD_IDLE; wait_in = '0;
                     txv = 1'b1; tx = IDLE_BYTE;
                  end
               end
               PH_RD_IDLE, PH_WR_BUSY: begin
                  if (req.rx_byte == IDLE_BYTE) begin
                     done = 1'b1; st = ST_OK;
                  end else if (wait_ff > tmo_ff) begin
                     done = 1'b1; st = ST_TIMEOUT;
                  end else begin
                     txv = 1'b1; tx = IDLE_BYTE;
                  end
               end
               PH_WR_GAP: begin
                  phase_in = PH_WR_TOKEN; txv = 1'b1; tx = DATA_TOKEN;
               end
               PH_WR_TOKEN: begin
                  cnt_in = '0; phase_in = PH_WR_REQ;
               end
               PH_WR_DATA: begin
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_in < CNT_W'(BLOCK_BYTES)) begin
                     phase_in = PH_WR_REQ;
                  end else begin
                     cnt_in = '0; phase_in = PH_WR_CRC;
                     txv = 1'b1; tx = IDLE_BYTE;
                  end
               end
               PH_WR_CRC: begin
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_in >= CNT_W'(2)) phase_in = PH_WR_RESP;
                  txv = 1'b1; tx = IDLE_BYTE;
               end
               PH_WR_RESP: begin
                  if (req.rx_byte[4:0] != DRESP_OK) begin
                     done = 1'b1; st = ST_REJECT;
                  end else begin
                     phase_in = PH_WR_BUSY; wait_in = '0;
                     txv = 1'b1; tx = IDLE_BYTE;
                  end
               end
               default: ;
            endcase
         end
         OP_WBYTE: begin
            if (phase_ff == PH_WR_REQ) begin
               phase_in = PH_WR_DATA; txv = 1'b1; tx = req.write_byte;
            end
         end
         default: ;
      endcase

      // delay phases; at most two steps can chain (burst -> select -> CMD0)
      if ((req.opcode == OP_TICK || req.opcode == OP_XDONE) && !done) begin
         if (phase_in == PH_DLY_BURST && wait_in >= settle_ff) begin
            sel_in = 1'b1; phase_in = PH_DLY_CS; wait_in = '0;
         end
         if (phase_in == PH_DLY_CS && wait_in >= settle_ff) begin
            go_cmd = 1'b1; nxt_cmd = CMD_GO_IDLE; nxt_arg = '0;
         end else if (phase_in == PH_DLY_CMD0 && wait_in >= settle_ff) begin
            go_cmd = 1'b1; nxt_cmd = CMD_IF_COND; nxt_arg = ARG_IF_COND;
         end
      end

      if (go_cmd) begin
         frame_in = nxt_frame; phase_in = PH_CMD_PRE;
         txv = 1'b1; tx = IDLE_BYTE;
      end
      if (done) begin
         phase_in = PH_IDLE;
         if (st == ST_BUSY) phase_in = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; cnt_ff <= '0; frame_ff <= '0;
         wait_ff <= '0; loop_ff <= '0; crc_run_ff <= '0; crc_rx_ff <= '0;
         sel_ff <= 1'b0; fast_ff <= 1'b0; r1_ff <= '0;
         tmo_ff <= 16'd1000; settle_ff <= 16'd100;
         vld_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_TIMEOUT) tmo_ff <= csr_wdata;
            else settle_ff <= csr_wdata;
         end
         if (take) begin
            phase_ff <= phase_in; cnt_ff <= cnt_in; frame_ff <= frame_in;
            wait_ff <= wait_in; loop_ff <= loop_in; crc_run_ff <= crc_run_in;
            crc_rx_ff <= crc_rx_in; sel_ff <= sel_in; fast_ff <= fast_in;
            r1_ff <= r1_in;
            vld_ff <= 1'b1;
         end else if (rsp.ready) begin
            vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         o_txv_ff <= txv; o_tx_ff <= tx; o_rdv_ff <= rdv; o_rd_ff <= rd;
         o_done_ff <= done; o_st_ff <= st;
      end
   end

   assign rsp.valid          = vld_ff;
   assign rsp.tx_valid       = o_txv_ff;
   assign rsp.tx_byte        = o_tx_ff;
   assign rsp.chip_select_on = sel_ff;
   assign rsp.read_valid     = o_rdv_ff;
   assign rsp.read_data      = o_rd_ff;
   assign rsp.write_request  = (phase_ff == PH_WR_REQ);
   assign rsp.done_res       = o_done_ff;
   assign rsp.status         = o_st_ff;
   assign rsp.fast_clock     = fast_ff;

`ifndef SYNTH
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(phase_ff))
      else $error("phase not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.tx_byte))
      else $error("response dropped while stalled");
   a_idle_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.done_res && rsp.status != ST_BUSY |-> phase_ff == PH_IDLE)
      else $error("done without return to idle");
   a_fast: assert property (@(posedge clock) disable iff (reset)
      rsp.fast_clock |-> rsp.chip_select_on)
      else $error("fast clock without select");
`endif

endmodule
`default_nettype wire

@@ tb/sd_card_spi_host_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// SD card SPI host sequencer testbench
// Drives host requests and emulated card replies into the sequencer. A local
// behavioural copy of the sequencer predicts each response, and every
// response taken from the block is compared against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module sd_card_spi_host_sequencer_tb;
   import sdspi_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEM_TARGET    = 1500;
   localparam int MIN_ROUNDS     = 8;

   typedef enum int {
      S_IDLE, S_BURST, S_DLY_BURST, S_DLY_CS, S_DLY_CMD0, S_CMD_PRE, S_CMD_FRAME,
      S_CMD_POLL, S_CMD_EXTRA, S_RD_TOKEN, S_RD_DATA, S_RD_CRC, S_RD_IDLE,
      S_WR_GAP, S_WR_TOKEN, S_WR_REQ, S_WR_DATA, S_WR_CRC, S_WR_RESP, S_WR_BUSY
   } seq_phase_e;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       chip_select_on;
      logic       read_valid;
      logic [7:0] read_data;
      logic       write_request;
      logic       done_res;
      status_type status;
      logic       fast_clock;
   } seq_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   sdspi_req_if req_ch ();
   sdspi_rsp_if rsp_ch ();

   sd_card_spi_host_sequencer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [15:0] cfg_timeout, cfg_settle;
   seq_phase_e  ph;
   int          byte_cnt;
   logic [47:0] frame;
   logic [15:0] wait_tmr, loop_tmr, crc_calc, crc_rx;
   logic        sel_level, fast_mode;
   logic [7:0]  r1_last;
   seq_result_t nxt;

   seq_result_t expected_results[$];
   int  errors = 0;
   int  items_sent = 0;
   int  responses_seen = 0;
   int  done_by_status[8];
   int  idle_cycles = 0;
   bit  gaps_on = 1'b1;
   bit  stalls_on = 1'b1;
   int  hold_off = 0;
   int  stall_cnt = 0;

   function automatic void put_byte(input logic [7:0] b);
      nxt.tx_valid = 1'b1;
      nxt.tx_byte  = b;
   endfunction

   function automatic void finish_op(input status_type st);
      nxt.done_res = 1'b1;
      nxt.status   = st;
      ph = S_IDLE;
   endfunction

   function automatic logic [6:0] cmd_crc7(input logic [39:0] body);
      logic [6:0] c;
      logic       fb;
      c = '0;
      for (int i = 39; i >= 0; i--) begin
         fb = body[i] ^ c[6];
         c  = {c[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
      end
      return c;
   endfunction

   function automatic logic [15:0] data_crc16(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {b, 8'h00};
      repeat (8) c = {c[14:0], 1'b0} ^ (c[15] ? 16'h1021 : 16'h0000);
      return c;
   endfunction

   function automatic void start_cmd(input logic [5:0] cmd, input logic [31:0] arg);
      logic [39:0] body;
      body  = {2'b01, cmd, arg};
      frame = {body, cmd_crc7(body), 1'b1};
      ph    = S_CMD_PRE;
      put_byte(IDLE_BYTE);
   endfunction

   function automatic void acmd_round();
      if (loop_tmr > cfg_timeout) finish_op(ST_TIMEOUT);
      else start_cmd(CMD_APP, '0);
   endfunction

   function automatic void poll_again();
      if (wait_tmr > cfg_timeout) finish_op(ST_TIMEOUT);
      else put_byte(IDLE_BYTE);
   endfunction

   function automatic void cmd_done();
      case (frame[45:40])
         CMD_GO_IDLE: begin
            if (r1_last != R1_IDLE) finish_op(ST_BAD_R1);
            else begin
               ph = S_DLY_CMD0;
               wait_tmr = '0;
            end
         end
         CMD_IF_COND: begin
            if (r1_last != R1_IDLE) finish_op(ST_BAD_R1);
            else begin
               loop_tmr = '0;
               acmd_round();
            end
         end
         CMD_APP: begin
            if (r1_last != R1_IDLE) finish_op(ST_BAD_R1);
            else start_cmd(CMD_SD_SEND_OP, ARG_HCS);
         end
         CMD_SD_SEND_OP: begin
            if (r1_last == 8'h00) begin
               fast_mode = 1'b1;
               finish_op(ST_OK);
            end else acmd_round();
         end
         CMD_READ_BLK: begin
            if (r1_last != 8'h00) finish_op(ST_BAD_R1);
            else begin
               ph = S_RD_TOKEN;
               wait_tmr = '0;
               put_byte(IDLE_BYTE);
            end
         end
         default: begin
            if (r1_last != 8'h00) finish_op(ST_BAD_R1);
            else begin
               ph = S_WR_GAP;
               put_byte(IDLE_BYTE);
            end
         end
      endcase
   endfunction

   function automatic bit in_settle();
      return ph == S_DLY_BURST || ph == S_DLY_CS || ph == S_DLY_CMD0;
   endfunction

   function automatic void run_settle();
      while (in_settle() && wait_tmr >= cfg_settle) begin
         if (ph == S_DLY_BURST) begin
            sel_level = 1'b1;
            ph = S_DLY_CS;
            wait_tmr = '0;
         end else if (ph == S_DLY_CS) start_cmd(CMD_GO_IDLE, '0);
         else start_cmd(CMD_IF_COND, ARG_IF_COND);
      end
   endfunction

   function automatic void byte_exchanged(input logic [7:0] rx);
      case (ph)
         S_BURST: begin
            byte_cnt++;
            if (byte_cnt < 10) put_byte(IDLE_BYTE);
            else begin
               ph = S_DLY_BURST;
               wait_tmr = '0;
            end
         end
         S_CMD_PRE: begin
            byte_cnt = 0;
            ph = S_CMD_FRAME;
            put_byte(frame[47:40]);
         end
         S_CMD_FRAME: begin
            byte_cnt++;
            if (byte_cnt < 6) put_byte(frame[47 - 8 * byte_cnt -: 8]);
            else begin
               ph = S_CMD_POLL;
               wait_tmr = '0;
               put_byte(IDLE_BYTE);
            end
         end
         S_CMD_POLL: begin
            if (rx[7]) poll_again();
            else begin
               r1_last = rx;
               if (frame[45:40] == CMD_IF_COND) begin
                  byte_cnt = 0;
                  ph = S_CMD_EXTRA;
                  put_byte(IDLE_BYTE);
               end else cmd_done();
            end
         end
         S_CMD_EXTRA: begin
            byte_cnt++;
            if (byte_cnt < 4) put_byte(IDLE_BYTE);
            else cmd_done();
         end
         S_RD_TOKEN: begin
            if (rx == DATA_TOKEN) begin
               byte_cnt = 0;
               crc_calc = '0;
               ph = S_RD_DATA;
               put_byte(IDLE_BYTE);
            end else poll_again();
         end
         S_RD_DATA: begin
            nxt.read_valid = 1'b1;
            nxt.read_data  = rx;
            crc_calc = data_crc16(crc_calc, rx);
            byte_cnt++;
            if (byte_cnt >= BLOCK_BYTES) begin
               byte_cnt = 0;
               ph = S_RD_CRC;
            end
            put_byte(IDLE_BYTE);
         end
         S_RD_CRC: begin
            crc_rx = {crc_rx[7:0], rx};
            byte_cnt++;
            if (byte_cnt < 2) put_byte(IDLE_BYTE);
            else if (crc_rx != crc_calc) finish_op(ST_CRC);
            else begin
               ph = S_RD_IDLE;
               wait_tmr = '0;
               put_byte(IDLE_BYTE);
            end
         end
         S_RD_IDLE, S_WR_BUSY: begin
            if (rx == IDLE_BYTE) finish_op(ST_OK);
            else poll_again();
         end
         S_WR_GAP: begin
            ph = S_WR_TOKEN;
            put_byte(DATA_TOKEN);
         end
         S_WR_TOKEN: begin
            byte_cnt = 0;
            ph = S_WR_REQ;
         end
         S_WR_DATA: begin
            byte_cnt++;
            if (byte_cnt < BLOCK_BYTES) ph = S_WR_REQ;
            else begin
               byte_cnt = 0;
               ph = S_WR_CRC;
               put_byte(IDLE_BYTE);
            end
         end
         S_WR_CRC: begin
            byte_cnt++;
            if (byte_cnt >= 2) ph = S_WR_RESP;
            put_byte(IDLE_BYTE);
         end
         S_WR_RESP: begin
            if (rx[4:0] != DRESP_OK) finish_op(ST_REJECT);
            else begin
               ph = S_WR_BUSY;
               wait_tmr = '0;
               put_byte(IDLE_BYTE);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic seq_result_t predict_step(input logic [2:0] op, input logic [31:0] addr,
                                                input logic [7:0] rx, input logic [7:0] wb);
      nxt = '0;
      nxt.status = ST_OK;
      case (op)
         OP_TICK: begin
            if (ph != S_IDLE) begin
               if (wait_tmr != TIMER_MAX) wait_tmr++;
               if (loop_tmr != TIMER_MAX) loop_tmr++;
               run_settle();
            end
         end
         OP_INIT, OP_READ, OP_WRITE: begin
            if (ph != S_IDLE) begin
               nxt.done_res = 1'b1;
               nxt.status   = ST_BUSY;
            end else if (op == OP_INIT) begin
               sel_level = 1'b0;
               fast_mode = 1'b0;
               byte_cnt  = 0;
               ph = S_BURST;
               put_byte(IDLE_BYTE);
            end else start_cmd(op == OP_READ ? CMD_READ_BLK : CMD_WRITE_BLK, addr);
         end
         OP_XDONE: begin
            byte_exchanged(rx);
            run_settle();
         end
         OP_WBYTE: begin
            if (ph == S_WR_REQ) begin
               ph = S_WR_DATA;
               put_byte(wb);
            end
         end
         default: ;
      endcase
      nxt.chip_select_on = sel_level;
      nxt.write_request  = (ph == S_WR_REQ);
      nxt.fast_clock     = fast_mode;
      return nxt;
   endfunction

   // receiver side: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_ch.ready = 1'b0;
      end else if (stall_cnt > 0) begin
         stall_cnt--;
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = 1'b1;
         if (stalls_on && $urandom_range(3) == 0)
            stall_cnt = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      end
   end

   always @(posedge clock) begin
      seq_result_t got, exp_r;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d responses outstanding",
                     $realtime, expected_results.size());
            $display("FAIL");
            $finish;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.tx_valid, rsp_ch.tx_byte, rsp_ch.chip_select_on, rsp_ch.read_valid,
                    rsp_ch.read_data, rsp_ch.write_request, rsp_ch.done_res,
                    status_type'(rsp_ch.status), rsp_ch.fast_clock};
            responses_seen++;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected response %p", $realtime, got);
            end else begin
               exp_r = expected_results.pop_front();
               if (got !== exp_r) begin
                  errors++;
                  $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
               end
               if (exp_r.done_res) done_by_status[exp_r.status]++;
            end
         end
      end
   end

   task automatic send_req(input logic [2:0] op, input logic [31:0] addr,
                           input logic [7:0] rx, input logic [7:0] wb);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(2) == 0)
         gap = ($urandom_range(15) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
      if (gap > 0) begin
         @(negedge clock) req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.opcode = op;
      req_ch.block_address = addr;
      req_ch.rx_byte = rx;
      req_ch.write_byte = wb;
      do @(posedge clock); while (!req_ch.ready);
      expected_results.push_back(predict_step(op, addr, rx, wb));
      items_sent++;
   endtask

   task automatic pause_sender();
      @(negedge clock) req_ch.valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] val);
      pause_sender();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock) csr_write_enable = 1'b0;
      if (idx == CSR_TIMEOUT) cfg_timeout = val;
      else cfg_settle = val;
   endtask

   task automatic send_noise();
      send_req(3'($urandom_range(7)), $urandom, 8'($urandom), 8'($urandom));
   endtask

   // byte the emulated card returns for the current sequencer step
   function automatic logic [7:0] card_reply();
      int r;
      r = $urandom_range(19);
      case (ph)
         S_CMD_POLL: begin
            if (r < 2) return IDLE_BYTE;
            if (r == 2) return 8'($urandom);
            case (frame[45:40])
               CMD_GO_IDLE, CMD_IF_COND, CMD_APP: return R1_IDLE;
               CMD_SD_SEND_OP: return (r < 11) ? 8'h00 : R1_IDLE;
               default: return 8'h00;
            endcase
         end
         S_RD_TOKEN: return (r < 16) ? DATA_TOKEN : ((r < 19) ? IDLE_BYTE : 8'($urandom));
         S_RD_CRC: return (byte_cnt == 0 ? crc_calc[15:8] : crc_calc[7:0]) ^ (r == 0 ? 8'h10 : 8'h00);
         S_RD_IDLE, S_WR_BUSY: return (r < 14) ? IDLE_BYTE : 8'h00;
         S_WR_RESP: return (r < 17) ? {3'($urandom), DRESP_OK} : 8'($urandom);
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic run_card();
      int guard;
      guard = 0;
      while (ph != S_IDLE && guard < 6000) begin
         guard++;
         if (in_settle() || $urandom_range(12) == 0) send_req(OP_TICK, $urandom, 8'($urandom), 8'($urandom));
         else if ($urandom_range(60) == 0) send_noise();
         else if (ph == S_WR_REQ) send_req(OP_WBYTE, $urandom, 8'($urandom), 8'($urandom));
         else send_req(OP_XDONE, $urandom, card_reply(), 8'($urandom));
      end
   endtask

   task automatic test_idle_noise();
      send_req(OP_TICK, '0, '0, '0);
      send_req(OP_XDONE, 32'hFFFF_FFFF, 8'hFF, 8'h00);
      send_req(OP_WBYTE, '0, 8'h00, 8'hFF);
      send_req(3'd6, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_req(3'd7, '0, '0, '0);
   endtask

   task automatic test_init();
      write_csr(CSR_SETTLE, 16'd0);
      write_csr(CSR_TIMEOUT, 16'd5);
      send_req(OP_INIT, '0, '0, '0);
      send_req(OP_READ, 32'h1234_5678, '0, '0);
      send_req(OP_WRITE, '0, '0, '0);
      send_req(OP_INIT, '0, '0, '0);
      run_card();
   endtask

   task automatic test_read_extremes();
      write_csr(CSR_SETTLE, 16'hFFFF);
      write_csr(CSR_TIMEOUT, 16'hFFFF);
      send_req(OP_READ, '0, '0, '0);
      run_card();
      // zero timeout: one tick then a missing token ends the read
      write_csr(CSR_TIMEOUT, 16'd0);
      send_req(OP_READ, 32'hFFFF_FFFF, '0, '0);
      while (ph != S_IDLE && ph != S_RD_TOKEN)
         send_req(OP_XDONE, '0, card_reply(), '0);
      if (ph == S_RD_TOKEN) begin
         send_req(OP_TICK, '0, '0, '0);
         send_req(OP_XDONE, '0, IDLE_BYTE, '0);
      end
   endtask

   task automatic test_write();
      write_csr(CSR_TIMEOUT, 16'd1000);
      send_req(OP_WRITE, $urandom, '0, '0);
      run_card();
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      hold_off = 300;
      repeat (40) send_req(OP_TICK, $urandom, 8'($urandom), 8'($urandom));
      pause_sender();
      gaps_on = 1'b1;
   endtask

   task automatic test_random();
      int rounds, s;
      rounds = 0;
      write_csr(CSR_SETTLE, 16'd2);
      while (items_sent < ITEM_TARGET || rounds < MIN_ROUNDS) begin
         rounds++;
         gaps_on   = $urandom_range(3) != 0;
         stalls_on = $urandom_range(3) != 0;
         if (ph == S_IDLE && $urandom_range(4) == 0) begin
            write_csr(CSR_TIMEOUT, ($urandom_range(3) == 0) ? 16'd1000 : 16'($urandom_range(12)));
            write_csr(CSR_SETTLE, 16'($urandom_range(3)));
         end
         s = $urandom_range(9);
         // block transfers are long, keep them out once the budget is spent
         if (items_sent >= ITEM_TARGET && (s == 4 || s == 5)) s = 0;
         if (s < 4) send_req(OP_INIT, $urandom, 8'($urandom), 8'($urandom));
         else if (s < 5) send_req(OP_READ, $urandom, 8'($urandom), 8'($urandom));
         else if (s < 6) send_req(OP_WRITE, $urandom, 8'($urandom), 8'($urandom));
         else repeat ($urandom_range(20, 5)) send_noise();
         run_card();
      end
      gaps_on = 1'b1;
      stalls_on = 1'b1;
   endtask

   initial begin
      cfg_timeout = 16'd1000;
      cfg_settle  = 16'd100;
      ph = S_IDLE;
      byte_cnt = 0;
      frame = '0;
      wait_tmr = '0;
      loop_tmr = '0;
      crc_calc = '0;
      crc_rx = '0;
      sel_level = 1'b0;
      fast_mode = 1'b0;
      r1_last = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_TICK;
      req_ch.block_address = '0;
      req_ch.rx_byte = '0;
      req_ch.write_byte = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      test_idle_noise();
      test_init();
      test_read_extremes();
      test_write();
      test_backpressure();
      test_random();
      pause_sender();
      repeat (10) @(posedge clock);

      $display("%0d requests, %0d responses checked, %0d errors", items_sent, responses_seen, errors);
      $display("completions ok %0d, bad R1 %0d, timeout %0d, CRC %0d, rejected %0d, busy %0d",
               done_by_status[ST_OK], done_by_status[ST_BAD_R1], done_by_status[ST_TIMEOUT],
               done_by_status[ST_CRC], done_by_status[ST_REJECT], done_by_status[ST_BUSY]);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ sd_card_spi_host_sequencer.f @@
sv/sdspi_pkg.sv
sv/sdspi_req_if.sv
sv/sdspi_rsp_if.sv
sv/sd_card_spi_host_sequencer.sv
tb/sd_card_spi_host_sequencer_tb.sv
